// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== rtl/edd_pkg.sv =====
package edd_pkg;

   // String capacity and derived widths
   localparam int MAX_LEN  = 64;
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DIST_W   = 7;
   localparam int DIST_MAX = 127;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_APPEND_FIRST  = 2'd0,
      OP_APPEND_SECOND = 2'd1,
      OP_COMPUTE       = 2'd2
   } op_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROW,
      ST_CELL
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic append_first;
      logic append_second;
      logic init_rows;
      logic start_row;
      logic step_cell;
      logic emit_fast;
      logic emit_cell;
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic len_zero;
      logic last_col;
      logic last_row;
   } dp_sts_type;

   // Clamp a cost value to the result field
   function automatic logic [DIST_W-1:0] sat_dist(input logic [LEN_W-1:0] v);
      logic [DIST_W-1:0] r;
      if (32'(v) > 32'(DIST_MAX)) begin
         r = DIST_W'(DIST_MAX);
      end else begin
         r = DIST_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== rtl/edd_datapath.sv =====
module edd_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  edd_pkg::dp_cmd_type          cmd,
   input  logic [7:0]                   req_symbol,
   output edd_pkg::dp_sts_type          sts,
   output logic                         rsp_valid,
   output logic [edd_pkg::DIST_W-1:0]   rsp_distance,
   output logic                         rsp_overflow
);
   import edd_pkg::*;

   logic [7:0]       first_mem  [MAX_LEN];
   logic [7:0]       second_mem [MAX_LEN];
   logic [LEN_W-1:0] row_mem    [MAX_LEN];

   logic [LEN_W-1:0]  len_a_ff, len_a_in;
   logic [LEN_W-1:0]  len_b_ff, len_b_in;
   logic              ovf_ff, ovf_in;
   logic [LEN_W-1:0]  row_ff, row_in;
   logic [LEN_W-1:0]  col_ff, col_in;
   logic [LEN_W-1:0]  diag_ff, diag_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [7:0]        a_rd_ff;
   logic [7:0]        b_rd_ff;
   logic [LEN_W-1:0]  up_rd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic [LEN_W-1:0] up_val;
   logic [LEN_W-1:0] min_val;
   logic [LEN_W-1:0] cell_val;
   logic [LEN_W-1:0] row_m1;
   logic [LEN_W-1:0] col_m1;
   logic [IDX_W-1:0] rd_idx;
   logic             rd_en;
   logic             emit;

   // Cell arithmetic: the first row reads its column number instead of memory
   always_comb begin
      up_val  = (row_ff == LEN_W'(1)) ? col_ff : up_rd_ff;
      min_val = (diag_ff < up_val) ? diag_ff : up_val;
      if (left_ff < min_val) begin
         min_val = left_ff;
      end
      cell_val = (a_rd_ff == b_rd_ff) ? diag_ff : (min_val + LEN_W'(1));
      row_m1   = row_ff - LEN_W'(1);
      col_m1   = col_ff - LEN_W'(1);
      rd_idx   = cmd.start_row ? '0 : col_ff[IDX_W-1:0];
      rd_en    = cmd.start_row | cmd.step_cell;
      emit     = cmd.emit_fast | cmd.emit_cell;
   end

   // First string store: write on append, read one byte per row
   always_ff @(posedge clock) begin
      if (cmd.append_first && (len_a_ff != LEN_W'(MAX_LEN))) begin
         first_mem[len_a_ff[IDX_W-1:0]] <= req_symbol;
      end
      if (cmd.start_row) begin
         a_rd_ff <= first_mem[row_m1[IDX_W-1:0]];
      end
   end

   // Second string store: read one byte ahead of each cell
   always_ff @(posedge clock) begin
      if (cmd.append_second && (len_b_ff != LEN_W'(MAX_LEN))) begin
         second_mem[len_b_ff[IDX_W-1:0]] <= req_symbol;
      end
      if (rd_en) begin
         b_rd_ff <= second_mem[rd_idx];
      end
   end

   // Cost row store: write the finished cell, read the next column's upper value
   always_ff @(posedge clock) begin
      if (cmd.step_cell) begin
         row_mem[col_m1[IDX_W-1:0]] <= cell_val;
      end
      if (rd_en) begin
         up_rd_ff <= row_mem[rd_idx];
      end
   end

   // Next-state logic for lengths, counters and result
   always_comb begin
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      ovf_in       = ovf_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      diag_in      = diag_ff;
      left_in      = left_ff;
      rsp_valid_in = emit;
      rsp_dist_in  = rsp_dist_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // append, or drop and flag when full
      if (cmd.append_first) begin
         if (len_a_ff == LEN_W'(MAX_LEN)) begin
            ovf_in = 1'b1;
         end else begin
            len_a_in = len_a_ff + LEN_W'(1);
         end
      end
      if (cmd.append_second) begin
         if (len_b_ff == LEN_W'(MAX_LEN)) begin
            ovf_in = 1'b1;
         end else begin
            len_b_in = len_b_ff + LEN_W'(1);
         end
      end

      // sweep the table
      if (cmd.init_rows) begin
         row_in = LEN_W'(1);
      end
      if (cmd.start_row) begin
         col_in  = LEN_W'(1);
         diag_in = row_m1;
         left_in = row_ff;
      end
      if (cmd.step_cell) begin
         diag_in = up_val;
         left_in = cell_val;
         col_in  = col_ff + LEN_W'(1);
         if (col_ff == len_b_ff) begin
            row_in = row_ff + LEN_W'(1);
         end
      end

      // latch the result and clear the strings
      if (emit) begin
         rsp_dist_in = cmd.emit_fast ? sat_dist(len_a_ff | len_b_ff) : sat_dist(cell_val);
         rsp_ovf_in  = ovf_ff;
         len_a_in    = '0;
         len_b_in    = '0;
         ovf_in      = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         ovf_ff       <= ovf_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      diag_ff     <= diag_in;
      left_ff     <= left_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign sts.len_zero  = (len_a_ff == '0) || (len_b_ff == '0);
   assign sts.last_col  = (col_ff == len_b_ff);
   assign sts.last_row  = (row_ff == len_a_ff);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule

// ===== rtl/edd_controller.sv =====
module edd_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_opcode,
   input  edd_pkg::dp_sts_type sts,
   output edd_pkg::dp_cmd_type cmd,
   output logic                busy
);
   import edd_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               unique case (op_type'(req_opcode))
                  OP_APPEND_FIRST:  cmd.append_first  = 1'b1;
                  OP_APPEND_SECOND: cmd.append_second = 1'b1;
                  OP_COMPUTE: begin
                     if (sts.len_zero) begin
                        cmd.emit_fast = 1'b1;
                     end else begin
                        cmd.init_rows = 1'b1;
                        state_in      = ST_ROW;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ROW: begin
            cmd.start_row = 1'b1;
            state_in      = ST_CELL;
         end
         ST_CELL: begin
            cmd.step_cell = 1'b1;
            if (sts.last_col) begin
               if (sts.last_row) begin
                  cmd.emit_cell = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_ROW;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/edit_distance_engine_top.sv =====
// Append requests leave busy low, so a new transfer may follow at once.
// Compute with an empty string: the result strobe comes in the cycle after the transfer.
// Otherwise the sweep runs row by row, a row set-up state plus one cell per
// cycle through the cost row memory, and the strobe follows in the next cycle.
// Synchronous active-high reset empties both strings and clears the overflow flag.
// Results are shown for one cycle only; the receiver cannot stall.
module edit_distance_engine_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic [7:0]                 req_symbol,
   output logic                       rsp_valid,
   output logic [edd_pkg::DIST_W-1:0] rsp_distance,
   output logic                       rsp_overflow
);
   import edd_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequence the loads and the table sweep
   edd_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   // Hold the strings and evaluate the cells
   edd_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_symbol   (req_symbol),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_distance (rsp_distance),
      .rsp_overflow (rsp_overflow)
   );

endmodule

// ===== rtl/edd_checker.sv =====
`include "assert_macros.svh"

module edd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic [1:0]                 req_opcode,
   input logic                       rsp_valid,
   input logic [edd_pkg::DIST_W-1:0] rsp_distance,
   input logic                       rsp_overflow
);
   import edd_pkg::*;

   logic accept;
   logic accept_compute;

   assign accept         = start && !busy;
   assign accept_compute = accept && (req_opcode == OP_COMPUTE);

   // a load or an unused opcode leaves the block idle and silent
   `ASSERT_NEXT(a_load_quiet, clock, reset, accept && !accept_compute, !rsp_valid && !busy)
   // a compute either answers at once or starts the sweep
   `ASSERT_NEXT(a_compute_acts, clock, reset, accept_compute, rsp_valid || busy)
   // the end of a sweep always delivers a result
   `ASSERT_IMPL(a_sweep_result, clock, reset, !$past(reset) && $fell(busy), rsp_valid)
   // a distance never exceeds the string capacity
   `ASSERT_IMPL(a_dist_range, clock, reset, rsp_valid, 32'(rsp_distance) <= 32'(MAX_LEN))
   // a result never carries unknown bits
   `ASSERT_IMPL(a_result_known, clock, reset, rsp_valid, !$isunknown(rsp_distance) && !$isunknown(rsp_overflow))

endmodule

bind edit_distance_engine_top edd_checker u_edd_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_opcode   (req_opcode),
   .rsp_valid    (rsp_valid),
   .rsp_distance (rsp_distance),
   .rsp_overflow (rsp_overflow)
);

// ===== verif/tb_edit_distance_engine_top.sv =====
`timescale 1ns / 100ps

module tb_edit_distance_engine_top;
   import edd_pkg::*;

   // Opcode outside the defined set; the block must ignore it
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = MAX_LEN * (MAX_LEN + 1) + 16;
   localparam int REPORT_LINES = 40;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              overflow;
   } distance_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [1:0]        req_opcode = '0;
   logic [7:0]        req_symbol = '0;
   logic              busy;
   logic              rsp_valid;
   logic [DIST_W-1:0] rsp_distance;
   logic              rsp_overflow;

   // Shadow of the block's strings
   logic [7:0] first_bytes [MAX_LEN];
   logic [7:0] second_bytes [MAX_LEN];
   int         first_len = 0;
   int         second_len = 0;
   bit         dropped_seen = 1'b0;

   distance_result_type expected_distances [$];
   int  mismatch_count = 0;
   int  transfer_count = 0;
   int  result_count = 0;
   int  dropped_result_count = 0;
   bit  no_idle = 1'b0;

   edit_distance_engine_top uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_symbol   (req_symbol),
      .rsp_valid    (rsp_valid),
      .rsp_distance (rsp_distance),
      .rsp_overflow (rsp_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Unit-cost edit distance over the shadow strings, one cost row at a time
   function automatic logic [DIST_W-1:0] levenshtein_distance();
      int cost [0:MAX_LEN];
      int diag;
      int up;
      int cell_cost;
      int smallest;
      for (int j = 0; j <= second_len; j++) begin
         cost[j] = j;
      end
      for (int i = 1; i <= first_len; i++) begin
         diag = cost[0];
         cost[0] = i;
         for (int j = 1; j <= second_len; j++) begin
            up = cost[j];
            if (first_bytes[i-1] == second_bytes[j-1]) begin
               cell_cost = diag;
            end else begin
               smallest = (diag < up) ? diag : up;
               smallest = (cost[j-1] < smallest) ? cost[j-1] : smallest;
               cell_cost = smallest + 1;
            end
            diag = up;
            cost[j] = cell_cost;
         end
      end
      if (cost[second_len] > DIST_MAX) begin
         return DIST_W'(DIST_MAX);
      end
      return DIST_W'(cost[second_len]);
   endfunction

   // Apply one accepted transfer to the shadow state
   function automatic void predict_transfer(input logic [1:0] op, input logic [7:0] sym);
      distance_result_type r;
      case (op)
         OP_APPEND_FIRST: begin
            if (first_len >= MAX_LEN) begin
               dropped_seen = 1'b1;
            end else begin
               first_bytes[first_len] = sym;
               first_len++;
            end
         end
         OP_APPEND_SECOND: begin
            if (second_len >= MAX_LEN) begin
               dropped_seen = 1'b1;
            end else begin
               second_bytes[second_len] = sym;
               second_len++;
            end
         end
         OP_COMPUTE: begin
            r.distance = levenshtein_distance();
            r.overflow = dropped_seen;
            expected_distances.push_back(r);
            first_len = 0;
            second_len = 0;
            dropped_seen = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LINES) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   // Predict first, then check, so a same-cycle result would still find its entry
   always @(posedge clock) begin
      distance_result_type exp_r;
      if (!reset) begin
         if (start && !busy) begin
            transfer_count++;
            predict_transfer(req_opcode, req_symbol);
         end
         if (rsp_valid) begin
            result_count++;
            if (rsp_overflow) begin
               dropped_result_count++;
            end
            if (expected_distances.size() == 0) begin
               report_mismatch($sformatf("unexpected result distance=%0d overflow=%0b",
                                         rsp_distance, rsp_overflow));
            end else begin
               exp_r = expected_distances.pop_front();
               if (rsp_distance !== exp_r.distance) begin
                  report_mismatch($sformatf("distance got %0d want %0d",
                                            rsp_distance, exp_r.distance));
               end
               if (rsp_overflow !== exp_r.overflow) begin
                  report_mismatch($sformatf("overflow got %0b want %0b",
                                            rsp_overflow, exp_r.overflow));
               end
            end
         end
      end
   end

   // Present one request and hold it until the block takes it
   task automatic send_item(input logic [1:0] op, input logic [7:0] sym);
      @(negedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_symbol <= sym;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Mostly back-to-back, some short gaps, a few long ones
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Drop start for a random gap, with junk on the request fields meanwhile
   task automatic pause();
      int n;
      n = no_idle ? 0 : gap_cycles();
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         req_opcode <= 2'($urandom);
         req_symbol <= 8'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_and_pause(input logic [1:0] op, input logic [7:0] sym);
      send_item(op, sym);
      pause();
   endtask

   // Empty strings on either side; the symbol of a compute is ignored
   task automatic test_empty_strings();
      send_and_pause(OP_COMPUTE, 8'hFF);
      send_and_pause(OP_APPEND_FIRST, 8'h00);
      send_and_pause(OP_COMPUTE, 8'h00);
      send_and_pause(OP_APPEND_SECOND, 8'hFF);
      send_and_pause(OP_APPEND_SECOND, 8'hFE);
      send_and_pause(OP_COMPUTE, 8'hA5);
   endtask

   // Symbol extremes in both strings, with a match, a swap and substitutions
   task automatic test_extreme_symbols();
      send_and_pause(OP_APPEND_FIRST, 8'h00);
      send_and_pause(OP_APPEND_FIRST, 8'hFF);
      send_and_pause(OP_APPEND_FIRST, 8'h80);
      send_and_pause(OP_APPEND_SECOND, 8'hFF);
      send_and_pause(OP_APPEND_SECOND, 8'h00);
      send_and_pause(OP_APPEND_SECOND, 8'h80);
      send_and_pause(OP_APPEND_SECOND, 8'h7F);
      send_and_pause(OP_COMPUTE, 8'h00);
   endtask

   // Unused opcode between appends must leave the strings alone
   task automatic test_unused_opcode();
      send_and_pause(OP_APPEND_FIRST, 8'h41);
      send_and_pause(OP_UNUSED, 8'h42);
      send_and_pause(OP_APPEND_SECOND, 8'h41);
      send_and_pause(OP_UNUSED, 8'hFF);
      send_and_pause(OP_COMPUTE, 8'h00);
   endtask

   // Compute straight after compute finds both strings cleared
   task automatic test_back_to_back_compute();
      no_idle = 1'b1;
      send_and_pause(OP_APPEND_FIRST, 8'h5A);
      send_and_pause(OP_COMPUTE, 8'h00);
      send_and_pause(OP_COMPUTE, 8'h00);
      no_idle = 1'b0;
   endtask

   // Fill strings past capacity; the flag must clear after the compute
   task automatic test_capacity();
      for (int k = 0; k < MAX_LEN + 2; k++) begin
         send_and_pause(OP_APPEND_FIRST, 8'($urandom));
      end
      send_and_pause(OP_COMPUTE, 8'h00);
      send_and_pause(OP_COMPUTE, 8'h00);
      no_idle = 1'b1;
      for (int k = 0; k < MAX_LEN; k++) begin
         send_and_pause(OP_APPEND_FIRST, 8'($urandom_range(0, 3)));
         send_and_pause(OP_APPEND_SECOND, 8'($urandom_range(0, 3)));
      end
      send_and_pause(OP_APPEND_SECOND, 8'h00);
      send_and_pause(OP_COMPUTE, 8'h00);
      no_idle = 1'b0;
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return $urandom_range(0, 8);
      end else if (r < 95) begin
         return $urandom_range(9, 24);
      end
      return $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
   endfunction

   // Load two strings in random interleave, then compute; sprinkle noise
   task automatic test_random_sequences(input int target);
      int         sent;
      int         left_a;
      int         left_b;
      bit         narrow;
      logic [7:0] base;
      logic [7:0] sym;
      sent = 0;
      while (sent < target) begin
         left_a = pick_length();
         left_b = pick_length();
         narrow = ($urandom_range(0, 9) < 7);
         base = 8'($urandom);
         no_idle = ($urandom_range(0, 3) == 0);
         while (left_a + left_b > 0) begin
            if ($urandom_range(0, 19) == 0) begin
               send_and_pause(OP_UNUSED, 8'($urandom));
            end
            // A narrow alphabet gives plenty of matching bytes
            sym = narrow ? (base ^ 8'($urandom_range(0, 3))) : 8'($urandom);
            if (left_b == 0 || (left_a != 0 && $urandom_range(0, 1) == 0)) begin
               send_and_pause(OP_APPEND_FIRST, sym);
               left_a--;
            end else begin
               send_and_pause(OP_APPEND_SECOND, sym);
               left_b--;
            end
            sent++;
         end
         send_and_pause(OP_COMPUTE, 8'($urandom));
         sent++;
         if ($urandom_range(0, 9) == 0) begin
            send_and_pause(OP_COMPUTE, 8'($urandom));
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_strings();
      test_extreme_symbols();
      test_unused_opcode();
      test_back_to_back_compute();
      test_capacity();
      test_random_sequences(180);

      @(negedge clock);
      start <= 1'b0;
      while (expected_distances.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request transfers and %0d distance results.",
               transfer_count, result_count);
      $display("%0d results carried the dropped-byte flag; %0d mismatches logged.",
               dropped_result_count, mismatch_count);
      if (mismatch_count == 0 && expected_distances.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
